FILE: sv/gabb_pkg.sv
package gabb_pkg;

  // Largest image side that clipping honours; larger register values are capped.
  localparam int MaxImageDim = 4096;
  localparam logic [12:0] MaxImageDimW = 13'(MaxImageDim);

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_CHANNEL_MODE = 3'd2,
    REG_SOURCE_MODE  = 3'd3,
    REG_ORIGIN_X     = 3'd4,
    REG_ORIGIN_Y     = 3'd5,
    REG_TEXT_COLOUR  = 3'd6
  } cfg_reg_t;

  // Destination channel layouts. The unused code behaves as four channels.
  typedef enum logic [1:0] {
    CH_ONE   = 2'd0,
    CH_THREE = 2'd1,
    CH_FOUR  = 2'd2
  } chan_mode_t;

  // Glyph pixel formats.
  typedef enum logic {
    SRC_GREY = 1'b0,
    SRC_BGRA = 1'b1
  } src_mode_t;

  typedef struct packed {
    logic [7:0] glyph_col;
    logic [7:0] glyph_row;
    logic [7:0] src_blue;
    logic [7:0] src_green;
    logic [7:0] src_red;
    logic [7:0] src_alpha;
    logic [7:0] dst_chan0;
    logic [7:0] dst_chan1;
    logic [7:0] dst_chan2;
  } px_in_t;

  typedef struct packed {
    logic        write_enable;
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [7:0]  out_chan0;
    logic [7:0]  out_chan1;
    logic [7:0]  out_chan2;
    logic [7:0]  out_chan3;
  } px_out_t;

endpackage

FILE: sv/glyph_alpha_blend_blit_top.sv
// Channel   Signals                          Width   Direction
// -------   -------------------------------  ------  ---------
// pixel in  in_valid, in_ready, in_data      72      request in
// pixel out out_valid, out_ready, out_data   57      request out
// config    cfg_we, cfg_index, cfg_data      1+3+24  write only
//
// Each pixel request passes through the input register, then the result register;
// a new request is taken every cycle unless a stalled result fills both stages.
// The blend arithmetic lies between those two registers.
// Reset (rst, synchronous, active high) empties both stages and loads the
// register defaults; no clearing pass is needed.
// While a result waits on out_ready the input register can still take one more
// request, after which in_ready drops until the result is taken.
module glyph_alpha_blend_blit_top
  import gabb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  px_in_t      in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output px_out_t     out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  // Blend of one byte: floor((dst*(255-a) + src*a) * 25501 / 6502500).
  // Since 6502500 = 255 * 25500, the result is floor(n/255) plus a carry that
  // only arises for remainders of 253 and 254 with a large enough n.
  function automatic logic [7:0] blend8(input logic [7:0] dst, input logic [7:0] src,
                                        input logic [7:0] a);
    logic [7:0]  inv_a;
    logic [15:0] m0;
    logic [15:0] m1;
    logic [15:0] n;
    logic [23:0] n257;
    logic [7:0]  p_est;
    logic [16:0] prod255;
    logic [16:0] rem;
    logic [7:0]  quo;
    logic [16:0] rem_fix;
    logic        carry;
    inv_a   = 8'd255 - a;
    m0      = 16'(dst) * 16'(inv_a);
    m1      = 16'(src) * 16'(a);
    n       = m0 + m1;
    // n*257/65536 undershoots n/255 by far less than one, so one correction step.
    n257    = {n, 8'd0} + {8'd0, n};
    p_est   = n257[23:16];
    prod255 = {1'b0, p_est, 8'd0} - {9'd0, p_est};
    rem     = {1'b0, n} - prod255;
    if (rem >= 17'd255) begin
      quo     = p_est + 8'd1;
      rem_fix = rem - 17'd255;
    end else begin
      quo     = p_est;
      rem_fix = rem;
    end
    carry = ((rem_fix == 17'd254) && (n >= 16'd25500)) ||
            ((rem_fix == 17'd253) && (n >= 16'd51000));
    return quo + {7'd0, carry};
  endfunction

  // Configuration registers.
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [1:0]  channel_mode;
  logic        source_mode;
  logic [15:0] origin_x;
  logic [15:0] origin_y;
  logic [23:0] text_colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= MaxImageDimW;
      image_height <= MaxImageDimW;
      channel_mode <= CH_THREE;
      source_mode  <= SRC_GREY;
      origin_x     <= '0;
      origin_y     <= '0;
      text_colour  <= 24'hFFFFFF;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[12:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        REG_CHANNEL_MODE: channel_mode <= cfg_data[1:0];
        REG_SOURCE_MODE:  source_mode  <= cfg_data[0];
        REG_ORIGIN_X:     origin_x     <= cfg_data[15:0];
        REG_ORIGIN_Y:     origin_y     <= cfg_data[15:0];
        REG_TEXT_COLOUR:  text_colour  <= cfg_data;
        default: begin
          // An index beyond the register list is dropped.
        end
      endcase
    end
  end

  // Two-stage pipeline: input register, then result register.
  logic    s1_valid;
  px_in_t  s1_data;
  logic    s2_ready;
  px_out_t result_next;

  assign s2_ready = !out_valid || out_ready;
  assign in_ready = !s1_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      out_data <= result_next;
    end
  end

  // Clipping. Glyph coordinates are eight bits, so they are always inside the
  // glyph bound; only the image bounds matter. Sums are 17-bit two's complement.
  logic [16:0] dx;
  logic [16:0] dy;
  logic [12:0] w_cap;
  logic [12:0] h_cap;
  logic        in_image;

  assign dx    = {origin_x[15], origin_x} + {9'd0, s1_data.glyph_col};
  assign dy    = {origin_y[15], origin_y} + {9'd0, s1_data.glyph_row};
  assign w_cap = (image_width > MaxImageDimW) ? MaxImageDimW : image_width;
  assign h_cap = (image_height > MaxImageDimW) ? MaxImageDimW : image_height;
  assign in_image = !dx[16] && !dy[16] &&
                    (dx[15:0] < {3'd0, w_cap}) && (dy[15:0] < {3'd0, h_cap});

  // Colour path: grey glyphs paint the text colour, BGRA glyphs their own.
  logic [7:0] col_r;
  logic [7:0] col_g;
  logic [7:0] col_b;
  logic [7:0] blend0;
  logic [7:0] blend1;
  logic [7:0] blend2;

  always_comb begin
    if (source_mode == SRC_BGRA) begin
      col_r = s1_data.src_red;
      col_g = s1_data.src_green;
      col_b = s1_data.src_blue;
    end else begin
      col_r = text_colour[23:16];
      col_g = text_colour[15:8];
      col_b = text_colour[7:0];
    end
  end

  assign blend0 = blend8(s1_data.dst_chan0, col_r, s1_data.src_alpha);
  assign blend1 = blend8(s1_data.dst_chan1, col_g, s1_data.src_alpha);
  assign blend2 = blend8(s1_data.dst_chan2, col_b, s1_data.src_alpha);

  always_comb begin
    result_next = '0;
    if (in_image) begin
      result_next.write_enable = 1'b1;
      result_next.dest_x       = dx[11:0];
      result_next.dest_y       = dy[11:0];
      case (chan_mode_t'(channel_mode))
        CH_ONE: begin
          result_next.out_chan0 = blend0;
        end
        CH_THREE: begin
          result_next.out_chan0 = blend0;
          result_next.out_chan1 = blend1;
          result_next.out_chan2 = blend2;
        end
        default: begin
          // Four channels overwrite the pixel: white for grey glyphs, else RGBA.
          if (source_mode == SRC_BGRA) begin
            result_next.out_chan0 = s1_data.src_red;
            result_next.out_chan1 = s1_data.src_green;
            result_next.out_chan2 = s1_data.src_blue;
          end else begin
            result_next.out_chan0 = 8'd255;
            result_next.out_chan1 = 8'd255;
            result_next.out_chan2 = 8'd255;
          end
          result_next.out_chan3 = s1_data.src_alpha;
        end
      endcase
    end
  end

  // A clipped pixel carries an all-zero payload.
  a_clipped_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.write_enable |-> out_data == '0)
    else $error("clipped result carries a non-zero payload");

  // A held input moves on whenever the result register is free.
  a_s1_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_ready |=> out_valid)
    else $error("input stage did not advance into a free result stage");

  // An accepted request always lands in the input register.
  a_in_capture: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted request was not captured");

  // Back-pressure only when both stages are full and the output is stalled.
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("in_ready dropped without a full, stalled pipeline");

endmodule

FILE: dv/glyph_blit_checker.sv
`timescale 1ns / 100ps

module glyph_blit_checker
  import gabb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  px_in_t      in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  px_out_t     out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int unsigned failures,
  output int unsigned pending
);

  // Shadow copy of the configuration registers.
  logic [12:0]        width_q;
  logic [12:0]        height_q;
  logic [1:0]         chan_q;
  src_mode_t          src_q;
  logic signed [15:0] org_x_q;
  logic signed [15:0] org_y_q;
  logic [23:0]        colour_q;

  px_out_t pixels_due[$];

  function automatic logic [7:0] lerp_byte(logic [7:0] dst, logic [7:0] src, logic [7:0] a);
    longint n;
    n = longint'(dst) * (255 - longint'(a)) + longint'(src) * longint'(a);
    return 8'((n * 25501) / 6502500);
  endfunction

  function automatic px_out_t blend_pixel(px_in_t px);
    px_out_t    r;
    int         dx;
    int         dy;
    int         w;
    int         h;
    logic [7:0] cr;
    logic [7:0] cg;
    logic [7:0] cb;
    r  = '0;
    dx = int'(org_x_q) + int'(px.glyph_col);
    dy = int'(org_y_q) + int'(px.glyph_row);
    w  = (width_q > MaxImageDimW) ? MaxImageDim : int'(width_q);
    h  = (height_q > MaxImageDimW) ? MaxImageDim : int'(height_q);
    if (dx < 0 || dy < 0 || dx >= w || dy >= h) return r;
    r.write_enable = 1'b1;
    r.dest_x       = 12'(dx);
    r.dest_y       = 12'(dy);
    if (src_q == SRC_GREY) begin
      cr = colour_q[23:16];
      cg = colour_q[15:8];
      cb = colour_q[7:0];
    end else begin
      cr = px.src_red;
      cg = px.src_green;
      cb = px.src_blue;
    end
    case (chan_q)
      CH_ONE: begin
        r.out_chan0 = lerp_byte(px.dst_chan0, cr, px.src_alpha);
      end
      CH_THREE: begin
        r.out_chan0 = lerp_byte(px.dst_chan0, cr, px.src_alpha);
        r.out_chan1 = lerp_byte(px.dst_chan1, cg, px.src_alpha);
        r.out_chan2 = lerp_byte(px.dst_chan2, cb, px.src_alpha);
      end
      default: begin
        // Four channels overwrite: white for grey glyphs, else the glyph bytes.
        r.out_chan0 = (src_q == SRC_GREY) ? 8'hFF : cr;
        r.out_chan1 = (src_q == SRC_GREY) ? 8'hFF : cg;
        r.out_chan2 = (src_q == SRC_GREY) ? 8'hFF : cb;
        r.out_chan3 = px.src_alpha;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    px_out_t want;
    if (rst) begin
      width_q  = 13'd4096;
      height_q = 13'd4096;
      chan_q   = CH_THREE;
      src_q    = SRC_GREY;
      org_x_q  = '0;
      org_y_q  = '0;
      colour_q = 24'hFFFFFF;
      pixels_due.delete();
    end else begin
      // Predict with the settings in force before any write at this edge.
      if (in_valid && in_ready) pixels_due = {pixels_due, blend_pixel(in_data)};
      if (out_valid && out_ready) begin
        if (pixels_due.size() == 0) begin
          $error("result with no request outstanding");
          failures++;
        end else begin
          want = pixels_due.pop_front();
          check_field("write_enable", 32'(want.write_enable), 32'(out_data.write_enable));
          check_field("dest_x", 32'(want.dest_x), 32'(out_data.dest_x));
          check_field("dest_y", 32'(want.dest_y), 32'(out_data.dest_y));
          check_field("out_chan0", 32'(want.out_chan0), 32'(out_data.out_chan0));
          check_field("out_chan1", 32'(want.out_chan1), 32'(out_data.out_chan1));
          check_field("out_chan2", 32'(want.out_chan2), 32'(out_data.out_chan2));
          check_field("out_chan3", 32'(want.out_chan3), 32'(out_data.out_chan3));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_q  = cfg_data[12:0];
          REG_IMAGE_HEIGHT: height_q = cfg_data[12:0];
          REG_CHANNEL_MODE: chan_q   = cfg_data[1:0];
          REG_SOURCE_MODE:  src_q    = src_mode_t'(cfg_data[0]);
          REG_ORIGIN_X:     org_x_q  = cfg_data[15:0];
          REG_ORIGIN_Y:     org_y_q  = cfg_data[15:0];
          REG_TEXT_COLOUR:  colour_q = cfg_data;
          default: ;
        endcase
      end
    end
    pending = pixels_due.size();
  end

endmodule

FILE: dv/glyph_alpha_blend_blit_top_test.sv
`timescale 1ns / 100ps

module glyph_alpha_blend_blit_top_test;
  import gabb_pkg::*;

  localparam int          ClkHalf    = 4;
  localparam int          Phases     = 22;
  localparam int          PhaseItems = 50;
  // An index past the end of the register list; the block must ignore it.
  localparam logic [2:0]  RegSpare   = 3'd7;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  px_in_t      in_data;
  logic        out_valid;
  logic        out_ready;
  px_out_t     out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  int unsigned failures;
  int unsigned pending;

  // When set, neither side inserts idle cycles, so back-to-back traffic is seen.
  bit calm;

  glyph_alpha_blend_blit_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  glyph_blit_checker scoreboard (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .failures (failures),
    .pending  (pending)
  );

  always #(ClkHalf) clk = ~clk;

  // The slowest correct run takes only a fraction of this figure.
  initial begin
    #2000000;
    $display("glyph_alpha_blend_blit_top: mismatch");
    $finish;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic px_in_t mk_pixel(logic [7:0] col, logic [7:0] row, logic [7:0] b,
                                      logic [7:0] g, logic [7:0] r, logic [7:0] a,
                                      logic [7:0] d0, logic [7:0] d1, logic [7:0] d2);
    px_in_t px;
    px.glyph_col = col;
    px.glyph_row = row;
    px.src_blue  = b;
    px.src_green = g;
    px.src_red   = r;
    px.src_alpha = a;
    px.dst_chan0 = d0;
    px.dst_chan1 = d1;
    px.dst_chan2 = d2;
    return px;
  endfunction

  // Random pixel; the weight is pushed to its extremes half of the time, since
  // full transparency and full opacity are where the blend is most exposed.
  function automatic px_in_t random_pixel();
    logic [7:0] a;
    case ($urandom_range(0, 3))
      0:       a = 8'h00;
      1:       a = 8'hFF;
      default: a = 8'($urandom);
    endcase
    return mk_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    a, 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  // Every task below is entered just after a falling edge and returns just after
  // one, so all inputs change only on falling edges.

  // Registers may only change once every outstanding request has come back.
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic put_reg(logic [2:0] idx, logic [23:0] val);
    drain();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_regs(int w, int h, chan_mode_t cm, src_mode_t sm, int ox, int oy,
                          logic [23:0] colour);
    put_reg(REG_IMAGE_WIDTH, 24'(w));
    put_reg(REG_IMAGE_HEIGHT, 24'(h));
    put_reg(REG_CHANNEL_MODE, 24'(cm));
    put_reg(REG_SOURCE_MODE, 24'(sm));
    put_reg(REG_ORIGIN_X, 24'(ox));
    put_reg(REG_ORIGIN_Y, 24'(oy));
    put_reg(REG_TEXT_COLOUR, colour);
  endtask

  // Presents one request after a random pause and holds it until it is taken.
  // With no pause the next request follows in the very next cycle.
  task automatic send_pixel(px_in_t px);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = px;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Result side: a random stall before each result, then ready until one is taken.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    int          w;
    int          h;
    int          ox;
    int          oy;
    chan_mode_t  cm;
    logic [23:0] colour;

    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    calm      = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed part. First the reset settings: white text, three channels,
    // grey glyphs, origin at the corner. Corners of the glyph and both weights.
    send_pixel(mk_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 8'h12, 8'h34, 8'h56));
    send_pixel(mk_pixel(8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00));
    send_pixel(mk_pixel(8'd17, 8'd200, 8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'h00, 8'hFF));
    send_pixel(mk_pixel(8'd1, 8'd2, 8'hAA, 8'h55, 8'hAA, 8'h01, 8'hFF, 8'hFF, 8'hFF));
    drain();

    // A width above the largest image side is capped, so column 4096 is
    // clipped while 4095 is written; rows above the image are clipped too.
    set_regs(8191, 4096, CH_FOUR, SRC_GREY, 3900, -10, 24'h000000);
    send_pixel(mk_pixel(8'd195, 8'd10, 8'h00, 8'h00, 8'h00, 8'h9C, 8'h00, 8'h00, 8'h00));
    send_pixel(mk_pixel(8'd196, 8'd10, 8'h00, 8'h00, 8'h00, 8'h9C, 8'h00, 8'h00, 8'h00));
    send_pixel(mk_pixel(8'd0, 8'd9, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00));
    drain();

    // A zero width writes nothing at all.
    set_regs(0, 4096, CH_THREE, SRC_BGRA, 0, 0, 24'h123456);
    send_pixel(mk_pixel(8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00));
    drain();

    // The meaningless channel code behaves as four channels; a write to the
    // spare index must leave every register as it was.
    set_regs(4096, 0, CH_THREE, SRC_BGRA, 0, 0, 24'h123456);
    put_reg(REG_IMAGE_HEIGHT, 24'd4096);
    put_reg(REG_CHANNEL_MODE, 24'd3);
    put_reg(RegSpare, 24'hFFFFFF);
    send_pixel(mk_pixel(8'd5, 8'd6, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77));
    send_pixel(mk_pixel(8'd7, 8'd8, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF));
    drain();

    // One-channel images with each source format; only red takes part.
    set_regs(4096, 4096, CH_ONE, SRC_GREY, 0, 0, 24'hC08040);
    send_pixel(mk_pixel(8'd3, 8'd4, 8'h00, 8'h00, 8'h00, 8'h7F, 8'h20, 8'hFF, 8'hFF));
    put_reg(REG_SOURCE_MODE, 24'(SRC_BGRA));
    send_pixel(mk_pixel(8'd3, 8'd4, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(mk_pixel(8'd9, 8'd9, 8'h10, 8'h20, 8'hE0, 8'h40, 8'h80, 8'h00, 8'h00));
    drain();

    // A one-pixel image and the extreme origins: only the far glyph corner of
    // a glyph placed up and to the left lands on it.
    set_regs(1, 1, CH_THREE, SRC_BGRA, -255, -255, 24'hFFFFFF);
    send_pixel(mk_pixel(8'd255, 8'd255, 8'h01, 8'h02, 8'h03, 8'hC0, 8'hFE, 8'hFD, 8'hFC));
    send_pixel(mk_pixel(8'd254, 8'd255, 8'h01, 8'h02, 8'h03, 8'hC0, 8'hFE, 8'hFD, 8'hFC));
    drain();
    set_regs(4096, 4096, CH_FOUR, SRC_BGRA, 32767, -32768, 24'h000000);
    send_pixel(mk_pixel(8'd0, 8'd0, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07));
    put_reg(REG_ORIGIN_X, 24'hFF8000);
    put_reg(REG_ORIGIN_Y, 24'h007FFF);
    send_pixel(mk_pixel(8'd255, 8'd255, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07));
    drain();

    // Random part. Each phase picks a fresh setting and places the glyph so
    // that it straddles the image edges, giving clipped and written pixels.
    for (int p = 0; p < Phases; p++) begin
      case ($urandom_range(0, 5))
        0:       w = 1;
        1:       w = 4096;
        2:       w = $urandom_range(4097, 8191);
        3:       w = $urandom_range(1, 300);
        default: w = $urandom_range(1, 4096);
      endcase
      case ($urandom_range(0, 4))
        0:       h = 1;
        1:       h = 4096;
        2:       h = $urandom_range(4097, 8191);
        default: h = $urandom_range(1, 4096);
      endcase
      if ($urandom_range(0, 7) == 0) begin
        ox = $urandom_range(0, 65535) - 32768;
        oy = $urandom_range(0, 65535) - 32768;
      end else begin
        ox = int'($urandom_range(0, (w > 4096 ? 4096 : w) + 300)) - 280;
        oy = int'($urandom_range(0, (h > 4096 ? 4096 : h) + 300)) - 280;
      end
      cm     = chan_mode_t'($urandom_range(0, 3));
      colour = 24'($urandom);
      calm   = ($urandom_range(0, 3) == 0);
      set_regs(w, h, cm, src_mode_t'($urandom_range(0, 1)), ox, oy, colour);
      if ($urandom_range(0, 3) == 0) put_reg(RegSpare, 24'($urandom));
      for (int i = 0; i < PhaseItems; i++) send_pixel(random_pixel());
      drain();
    end

    // Allow the two pipeline stages to settle so that any stray result shows.
    repeat (6) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("glyph_alpha_blend_blit_top: match");
    end else begin
      $display("glyph_alpha_blend_blit_top: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/gabb_pkg.sv
sv/glyph_alpha_blend_blit_top.sv
dv/glyph_blit_checker.sv
dv/glyph_alpha_blend_blit_top_test.sv
